@@ rtl/pst_pkg.sv @@
// ----------------------------------------------------------------------------
// Scheduler package
// Shared types and codes of the thread scheduler with a timed delay queue.
// ----------------------------------------------------------------------------
package pst_pkg;

	typedef enum logic [2:0] {
		CMD_CREATE    = 3'd0,
		CMD_SET_PRIO  = 3'd1,
		CMD_WAIT      = 3'd2,
		CMD_ADVANCE   = 3'd3,
		CMD_READY     = 3'd4,
		CMD_BLOCK     = 3'd5,
		CMD_SCHEDULE  = 3'd6,
		CMD_UNUSED    = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		STS_OK       = 3'd0,
		STS_TOO_SOON = 3'd1,
		STS_FULL     = 3'd2,
		STS_NONE     = 3'd3,
		STS_IDLE     = 3'd4
	} status_t;

	localparam logic [1:0] REG_WAKE_TOL  = 2'd0;
	localparam logic [1:0] REG_MIN_DELAY = 2'd1;
	localparam logic [1:0] REG_IDLE      = 2'd2;

	localparam logic [29:0] WAKE_TOL_RESET  = 30'd999999;
	localparam logic [29:0] MIN_DELAY_RESET = 30'd1000000;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [3:0]  thread_sel;
		logic [7:0]  prio;
		logic [62:0] wake_time;
		logic [62:0] now_time;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  thread_out;
		logic [4:0]  woken_count;
		logic [62:0] next_wake;
		logic        next_wake_valid;
	} out_word_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [3:0]  sel;
		logic [7:0]  prio;
		logic [62:0] wake_time;
		logic [63:0] limit;
		logic        too_soon;
	} cmd_word_t;

endpackage

@@ rtl/pst_front.sv @@
// ----------------------------------------------------------------------------
// Scheduler front end
// Accepts command words and precomputes the wake limit and the early check.
// ----------------------------------------------------------------------------
module pst_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  pst_pkg::in_word_t   in_data,
	input  logic [29:0]         wake_tol,
	input  logic [29:0]         min_delay,
	input  logic                fifo_full,
	output logic                fifo_push,
	output pst_pkg::cmd_word_t  fifo_word
);

	logic               v_s1;
	pst_pkg::cmd_word_t word_s1;
	logic               take;
	logic [63:0]        min_sum;

	assign in_stall  = v_s1 && fifo_full;
	assign take      = in_valid && !in_stall;
	assign fifo_push = v_s1 && !fifo_full;
	assign fifo_word = word_s1;
	assign min_sum   = {1'b0, in_data.now_time} + {34'd0, min_delay};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (fifo_push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_s1.cmd       <= in_data.cmd;
			word_s1.sel       <= in_data.thread_sel;
			word_s1.prio      <= in_data.prio;
			word_s1.wake_time <= in_data.wake_time;
			word_s1.limit     <= {1'b0, in_data.now_time} + {34'd0, wake_tol};
			word_s1.too_soon  <= ({1'b0, in_data.wake_time} < min_sum);
		end
	end

endmodule

@@ rtl/pst_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// Scheduler command queue
// Two-entry queue between the front end and the execution unit.
// ----------------------------------------------------------------------------
module pst_cmd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pst_pkg::cmd_word_t  push_word,
	input  logic                pop,
	output logic                full,
	output logic                empty,
	output pst_pkg::cmd_word_t  head
);

	pst_pkg::cmd_word_t slot_q [2];
	logic               wr_q;
	logic               rd_q;
	logic [1:0]         cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_q <= !wr_q;
			end
			if (pop && !empty) begin
				rd_q <= !rd_q;
			end
			if ((push && !full) && !(pop && !empty)) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!(push && !full) && (pop && !empty)) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_q] <= push_word;
		end
	end

endmodule

@@ rtl/pst_back.sv @@
// ----------------------------------------------------------------------------
// Scheduler execution unit
// Holds the thread table and the sorted delay queue and runs each command.
// ----------------------------------------------------------------------------
module pst_back #(
	parameter int NUM_THREADS = 16,
	parameter int PRIO_BITS   = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [3:0]          idle_thread,
	input  logic                fifo_empty,
	input  pst_pkg::cmd_word_t  fifo_word,
	output logic                fifo_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output pst_pkg::out_word_t  out_data
);

	localparam int IW = $clog2(NUM_THREADS);
	localparam int CW = $clog2(NUM_THREADS + 1);
	localparam int KW = (CW > 4) ? CW : 4;

	typedef enum logic [1:0] {
		TS_NONE    = 2'd0,
		TS_READY   = 2'd1,
		TS_WAITING = 2'd2,
		TS_RUNNING = 2'd3
	} tstate_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WAKE,
		S_WAKE_LD,
		S_PICK,
		S_INS_RD,
		S_INS_CMP,
		S_DONE
	} fsm_t;

	fsm_t                 state_q;
	tstate_t              tstate_q [NUM_THREADS];
	logic [PRIO_BITS-1:0] prio_mem [NUM_THREADS];
	logic [62:0]          dq_time_mem [NUM_THREADS];
	logic [3:0]           dq_thread_mem [NUM_THREADS];

	pst_pkg::cmd_word_t   cur_q;
	logic [CW-1:0]        tc_q;
	logic [CW-1:0]        dcount_q;
	logic [IW-1:0]        head_q;
	logic [62:0]          head_time_q;
	logic [3:0]           head_thread_q;
	logic                 run_valid_q;
	logic [IW-1:0]        run_q;
	logic                 pick_after_q;
	logic [CW-1:0]        k_q;
	logic [CW-1:0]        scan_q;
	logic                 found_q;
	logic [IW-1:0]        best_q;
	logic [PRIO_BITS-1:0] best_prio_q;
	logic                 pv_s1;
	logic                 prdy_s1;
	logic [IW-1:0]        pidx_s1;
	logic [PRIO_BITS-1:0] pprio_s1;
	logic [2:0]           status_q;
	logic [3:0]           tout_q;
	logic [CW-1:0]        woken_q;
	logic [62:0]          rd_time_q;
	logic [3:0]           rd_thread_q;

	logic                 known;
	logic [IW-1:0]        sel_idx;
	logic [IW-1:0]        tc_idx;
	logic [IW-1:0]        head_nxt;
	logic [IW-1:0]        rd_addr;
	logic                 dq_we;
	logic [IW-1:0]        dq_wa;
	logic [62:0]          dq_wt;
	logic [3:0]           dq_wth;
	logic                 pw_en;
	logic [IW-1:0]        pw_addr;
	logic                 rd_later;

	function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [CW-1:0] r);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(r);
		if (s >= (CW+1)'(NUM_THREADS)) begin
			s = s - (CW+1)'(NUM_THREADS);
		end
		return IW'(s);
	endfunction

	assign known    = (KW'(fifo_word.sel) < KW'(tc_q));
	assign sel_idx  = IW'(fifo_word.sel);
	assign tc_idx   = IW'(tc_q);
	assign head_nxt = phys(head_q, CW'(1));
	assign fifo_pop = (state_q == S_IDLE) && !fifo_empty;
	assign rd_later = (rd_time_q > cur_q.wake_time);

	always_comb begin
		rd_addr = phys(head_q, k_q - CW'(1));
		if (state_q == S_WAKE) begin
			rd_addr = head_nxt;
		end
	end

	always_comb begin
		dq_we  = 1'b0;
		dq_wa  = phys(head_q, k_q);
		dq_wt  = cur_q.wake_time;
		dq_wth = cur_q.sel;
		if (state_q == S_INS_RD && k_q == '0) begin
			dq_we = 1'b1;
		end else if (state_q == S_INS_CMP) begin
			dq_we = 1'b1;
			if (rd_later) begin
				dq_wt  = rd_time_q;
				dq_wth = rd_thread_q;
			end
		end
	end

	always_comb begin
		pw_en   = 1'b0;
		pw_addr = sel_idx;
		if (fifo_pop) begin
			if (fifo_word.cmd == pst_pkg::CMD_CREATE && tc_q != CW'(NUM_THREADS)) begin
				pw_en   = 1'b1;
				pw_addr = tc_idx;
			end else if (fifo_word.cmd == pst_pkg::CMD_SET_PRIO && known) begin
				pw_en = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dq_we) begin
			dq_time_mem[dq_wa]   <= dq_wt;
			dq_thread_mem[dq_wa] <= dq_wth;
		end
		rd_time_q   <= dq_time_mem[rd_addr];
		rd_thread_q <= dq_thread_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (pw_en) begin
			prio_mem[pw_addr] <= PRIO_BITS'(fifo_word.prio);
		end
		pprio_s1 <= prio_mem[IW'(scan_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			for (int i = 0; i < NUM_THREADS; i++) begin
				tstate_q[i] <= TS_NONE;
			end
			cur_q         <= '0;
			tc_q          <= '0;
			dcount_q      <= '0;
			head_q        <= '0;
			head_time_q   <= '0;
			head_thread_q <= '0;
			run_valid_q   <= 1'b0;
			run_q         <= '0;
			pick_after_q  <= 1'b0;
			k_q           <= '0;
			scan_q        <= '0;
			found_q       <= 1'b0;
			best_q        <= '0;
			best_prio_q   <= '0;
			pv_s1         <= 1'b0;
			prdy_s1       <= 1'b0;
			pidx_s1       <= '0;
			status_q      <= pst_pkg::STS_OK;
			tout_q        <= '0;
			woken_q       <= '0;
			out_valid     <= 1'b0;
			out_data      <= '0;
		end else begin
			if (out_valid && !out_stall && state_q != S_DONE) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!fifo_empty) begin
						cur_q        <= fifo_word;
						status_q     <= pst_pkg::STS_OK;
						tout_q       <= '0;
						woken_q      <= '0;
						pick_after_q <= 1'b0;
						scan_q       <= '0;
						found_q      <= 1'b0;
						pv_s1        <= 1'b0;
						state_q      <= S_DONE;
						case (fifo_word.cmd)
							pst_pkg::CMD_CREATE: begin
								if (tc_q == CW'(NUM_THREADS)) begin
									status_q <= pst_pkg::STS_FULL;
								end else begin
									tstate_q[tc_idx] <= TS_READY;
									tout_q           <= 4'(tc_q);
									tc_q             <= tc_q + CW'(1);
								end
							end
							pst_pkg::CMD_WAIT: begin
								if (known) begin
									if (fifo_word.too_soon) begin
										status_q <= pst_pkg::STS_TOO_SOON;
									end else if (fifo_word.sel == idle_thread) begin
										status_q <= pst_pkg::STS_IDLE;
									end else if (dcount_q == CW'(NUM_THREADS)) begin
										status_q <= pst_pkg::STS_FULL;
									end else begin
										tstate_q[sel_idx] <= TS_WAITING;
										k_q               <= dcount_q;
										state_q           <= S_INS_RD;
									end
								end
							end
							pst_pkg::CMD_ADVANCE: begin
								state_q <= S_WAKE;
							end
							pst_pkg::CMD_READY: begin
								if (known) begin
									tstate_q[sel_idx] <= TS_READY;
								end
							end
							pst_pkg::CMD_BLOCK: begin
								if (known) begin
									tstate_q[sel_idx] <= TS_WAITING;
								end
							end
							pst_pkg::CMD_SCHEDULE: begin
								if (run_valid_q && tstate_q[run_q] == TS_RUNNING) begin
									tstate_q[run_q] <= TS_READY;
									pick_after_q    <= 1'b1;
									state_q         <= S_WAKE;
								end else begin
									state_q <= S_PICK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_WAKE: begin
					if (dcount_q != '0 && {1'b0, head_time_q} <= cur_q.limit) begin
						tstate_q[IW'(head_thread_q)] <= TS_READY;
						head_q   <= head_nxt;
						dcount_q <= dcount_q - CW'(1);
						woken_q  <= woken_q + CW'(1);
						if (dcount_q > CW'(1)) begin
							state_q <= S_WAKE_LD;
						end
					end else if (pick_after_q) begin
						state_q <= S_PICK;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_WAKE_LD: begin
					head_time_q   <= rd_time_q;
					head_thread_q <= rd_thread_q;
					state_q       <= S_WAKE;
				end
				S_PICK: begin
					if (pv_s1 && prdy_s1 && (!found_q || pprio_s1 > best_prio_q)) begin
						found_q     <= 1'b1;
						best_q      <= pidx_s1;
						best_prio_q <= pprio_s1;
					end
					if (scan_q < tc_q) begin
						prdy_s1 <= (tstate_q[IW'(scan_q)] == TS_READY);
						pidx_s1 <= IW'(scan_q);
						pv_s1   <= 1'b1;
						scan_q  <= scan_q + CW'(1);
					end else begin
						pv_s1 <= 1'b0;
						if (!pv_s1) begin
							state_q <= S_DONE;
							if (found_q) begin
								tstate_q[best_q] <= TS_RUNNING;
								run_q            <= best_q;
								run_valid_q      <= 1'b1;
								tout_q           <= 4'(best_q);
							end else begin
								run_valid_q <= 1'b0;
								run_q       <= '0;
								status_q    <= pst_pkg::STS_NONE;
							end
						end
					end
				end
				S_INS_RD: begin
					if (k_q == '0) begin
						head_time_q   <= cur_q.wake_time;
						head_thread_q <= cur_q.sel;
						dcount_q      <= dcount_q + CW'(1);
						state_q       <= S_DONE;
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (rd_later) begin
						k_q     <= k_q - CW'(1);
						state_q <= S_INS_RD;
					end else begin
						dcount_q <= dcount_q + CW'(1);
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid || !out_stall) begin
						out_valid                <= 1'b1;
						out_data.status          <= status_q;
						out_data.thread_out      <= tout_q;
						out_data.woken_count     <= 5'(woken_q);
						out_data.next_wake       <= (dcount_q != '0) ? head_time_q : 63'd0;
						out_data.next_wake_valid <= (dcount_q != '0);
						state_q                  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/priority_scheduler_timed_wakeup_top.sv @@
// ----------------------------------------------------------------------------
// Priority scheduler with timed wakeup
// A command passes the front-end register and the command queue before the
// execution unit runs it. An advance steps through each woken entry, a wait
// shifts each later queue entry up one place, and a schedule scans each
// created thread, after the wake steps on a demotion. One command runs at once.
// Reset clears the thread table, the queue count and the registers to defaults.
// ----------------------------------------------------------------------------
module priority_scheduler_timed_wakeup_top #(
	parameter int NUM_THREADS = 16,
	parameter int PRIO_BITS   = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  pst_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output pst_pkg::out_word_t out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [29:0]        wake_tol_q;
	logic [29:0]        min_delay_q;
	logic [3:0]         idle_q;
	logic               fifo_full;
	logic               fifo_empty;
	logic               fifo_push;
	logic               fifo_pop;
	pst_pkg::cmd_word_t push_word;
	pst_pkg::cmd_word_t head_word;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wake_tol_q  <= pst_pkg::WAKE_TOL_RESET;
			min_delay_q <= pst_pkg::MIN_DELAY_RESET;
			idle_q      <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				pst_pkg::REG_WAKE_TOL:  wake_tol_q  <= pwdata[29:0];
				pst_pkg::REG_MIN_DELAY: min_delay_q <= pwdata[29:0];
				pst_pkg::REG_IDLE:      idle_q      <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			pst_pkg::REG_WAKE_TOL:  prdata = {2'd0, wake_tol_q};
			pst_pkg::REG_MIN_DELAY: prdata = {2'd0, min_delay_q};
			pst_pkg::REG_IDLE:      prdata = {28'd0, idle_q};
			default:                prdata = '0;
		endcase
	end

	pst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.wake_tol  (wake_tol_q),
		.min_delay (min_delay_q),
		.fifo_full (fifo_full),
		.fifo_push (fifo_push),
		.fifo_word (push_word)
	);

	pst_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.push_word (push_word),
		.pop       (fifo_pop),
		.full      (fifo_full),
		.empty     (fifo_empty),
		.head      (head_word)
	);

	pst_back #(
		.NUM_THREADS (NUM_THREADS),
		.PRIO_BITS   (PRIO_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.idle_thread (idle_q),
		.fifo_empty  (fifo_empty),
		.fifo_word   (head_word),
		.fifo_pop    (fifo_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler testbench
// Drives random and directed scheduler commands through the valid/stall
// channels, writes the control registers between phases over the APB port, and
// compares every result word against a cycle-free model of the thread table
// and the sorted delay queue kept in a small scoreboard class.
// ----------------------------------------------------------------------------

class sched_scoreboard;
	logic [29:0] wake_tol;
	logic [29:0] min_delay;
	logic [3:0]  idle_id;
	logic [1:0]  tstate [16];
	logic [7:0]  tprio [16];
	int          created;
	bit          run_valid;
	int          run_id;
	logic [62:0] dq_time [$];
	int          dq_id [$];
	pst_pkg::out_word_t pending [$];
	int          errors;

	function new();
		wake_tol = pst_pkg::WAKE_TOL_RESET;
		min_delay = pst_pkg::MIN_DELAY_RESET;
		idle_id = 0;
		foreach (tstate[i]) begin
			tstate[i] = 0;
			tprio[i] = 0;
		end
		created = 0;
		run_valid = 0;
		run_id = 0;
		errors = 0;
	endfunction

	function int wake_due(logic [62:0] now);
		logic [63:0] lim;
		int n;
		lim = {1'b0, now} + wake_tol;
		n = 0;
		while (dq_time.size() > 0 && {1'b0, dq_time[0]} <= lim) begin
			tstate[dq_id[0]] = 1;
			void'(dq_time.pop_front());
			void'(dq_id.pop_front());
			n++;
		end
		return n;
	endfunction

	function void note_command(pst_pkg::in_word_t w);
		pst_pkg::out_word_t r;
		bit known;
		int pos;
		int best;
		r = '0;
		known = w.thread_sel < created;
		case (pst_pkg::cmd_t'(w.cmd))
			pst_pkg::CMD_CREATE: begin
				if (created >= 16) r.status = pst_pkg::STS_FULL;
				else begin
					tstate[created] = 1;
					tprio[created] = w.prio;
					r.thread_out = 4'(created);
					created++;
				end
			end
			pst_pkg::CMD_SET_PRIO: if (known) tprio[w.thread_sel] = w.prio;
			pst_pkg::CMD_WAIT: begin
				if (known) begin
					if ({1'b0, w.wake_time} < {1'b0, w.now_time} + min_delay)
						r.status = pst_pkg::STS_TOO_SOON;
					else if (w.thread_sel == idle_id) r.status = pst_pkg::STS_IDLE;
					else if (dq_time.size() >= 16) r.status = pst_pkg::STS_FULL;
					else begin
						tstate[w.thread_sel] = 2;
						pos = 0;
						while (pos < dq_time.size() && dq_time[pos] <= w.wake_time) pos++;
						dq_time.insert(pos, w.wake_time);
						dq_id.insert(pos, w.thread_sel);
					end
				end
			end
			pst_pkg::CMD_ADVANCE: r.woken_count = 5'(wake_due(w.now_time));
			pst_pkg::CMD_READY: if (known) tstate[w.thread_sel] = 1;
			pst_pkg::CMD_BLOCK: if (known) tstate[w.thread_sel] = 2;
			pst_pkg::CMD_SCHEDULE: begin
				if (run_valid && tstate[run_id] == 3) begin
					tstate[run_id] = 1;
					r.woken_count = 5'(wake_due(w.now_time));
				end
				best = -1;
				for (int i = 0; i < created; i++)
					if (tstate[i] == 1 && (best < 0 || tprio[i] > tprio[best])) best = i;
				if (best >= 0) begin
					tstate[best] = 3;
					run_id = best;
					run_valid = 1;
					r.thread_out = 4'(best);
				end else begin
					run_valid = 0;
					run_id = 0;
					r.status = pst_pkg::STS_NONE;
				end
			end
			default: ;
		endcase
		if (dq_time.size() > 0) begin
			r.next_wake = dq_time[0];
			r.next_wake_valid = 1;
		end
		pending.push_back(r);
	endfunction

	function void check_result(pst_pkg::out_word_t got);
		pst_pkg::out_word_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (got.status !== e.status || got.thread_out !== e.thread_out
				|| got.woken_count !== e.woken_count || got.next_wake !== e.next_wake
				|| got.next_wake_valid !== e.next_wake_valid) begin
			$display("%0t: mismatch expected %h actual %h", $time, e, got);
			errors++;
		end
	endfunction
endclass

module tb_top;
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	pst_pkg::in_word_t  in_data;
	logic        out_valid;
	logic        out_stall;
	pst_pkg::out_word_t out_data;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	sched_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	logic [62:0] clock_ns;

	priority_scheduler_timed_wakeup_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	initial begin
		sb = new();
		send_idle_pct = 0;
		recv_idle_pct = 0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
		if (arst_n && out_valid && !out_stall) sb.check_result(out_data);
	end

	task automatic send_word(pst_pkg::in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		sb.note_command(w);
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		int n;
		n = 0;
		in_valid <= 1'b0;
		while (sb.pending.size() > 0) @(posedge clk);
		while (n < 200) begin
			@(posedge clk);
			n++;
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			pst_pkg::REG_WAKE_TOL: sb.wake_tol = val[29:0];
			pst_pkg::REG_MIN_DELAY: sb.min_delay = val[29:0];
			default: sb.idle_id = val[3:0];
		endcase
	endtask

	function automatic pst_pkg::in_word_t make_cmd(pst_pkg::cmd_t c, logic [3:0] sel,
			logic [7:0] p, logic [62:0] wk, logic [62:0] nw);
		pst_pkg::in_word_t w;
		w.cmd = c;
		w.thread_sel = sel;
		w.prio = p;
		w.wake_time = wk;
		w.now_time = nw;
		return w;
	endfunction

	function automatic logic [62:0] rand63();
		return 63'({$urandom(), $urandom()});
	endfunction

	task automatic random_items(int count);
		pst_pkg::in_word_t w;
		int kind;
		logic [62:0] d;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(99);
			clock_ns = clock_ns + 63'($urandom_range(3000000));
			d = 63'($urandom_range(4000000));
			w = make_cmd(pst_pkg::cmd_t'($urandom_range(7)), 4'($urandom_range(15)),
				8'($urandom()), clock_ns + d, clock_ns);
			if (kind < 30) w.cmd = pst_pkg::CMD_WAIT;
			else if (kind < 45) w.cmd = pst_pkg::CMD_SCHEDULE;
			else if (kind < 55) w.cmd = pst_pkg::CMD_ADVANCE;
			else if (kind < 60) w.cmd = pst_pkg::CMD_CREATE;
			else if (kind < 63) begin
				w.wake_time = rand63();
				w.now_time = rand63();
			end
			if (sb.created > 0 && kind < 45 && $urandom_range(3) != 0)
				w.thread_sel = 4'($urandom_range(sb.created - 1));
			send_word(w);
		end
	endtask

	initial begin
		#20000000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		clock_ns = 63'd1000;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(make_cmd(pst_pkg::CMD_SCHEDULE, 0, 0, 0, 0));
		send_word(make_cmd(pst_pkg::CMD_CREATE, 0, 8'hFF, 0, 0));
		send_word(make_cmd(pst_pkg::CMD_CREATE, 0, 8'h00, 0, 0));
		send_word(make_cmd(pst_pkg::CMD_CREATE, 0, 8'hFF, 0, 0));
		send_word(make_cmd(pst_pkg::CMD_SET_PRIO, 1, 8'hA5, 0, 0));
		send_word(make_cmd(pst_pkg::CMD_SET_PRIO, 15, 8'h5A, 0, 0));
		send_word(make_cmd(pst_pkg::CMD_SCHEDULE, 0, 0, 0, 1000));
		send_word(make_cmd(pst_pkg::CMD_WAIT, 1, 0, 1500, 1000));
		send_word(make_cmd(pst_pkg::CMD_WAIT, 0, 0, 5000000, 1000));
		send_word(make_cmd(pst_pkg::CMD_WAIT, 1, 0, 3000000, 1000));
		send_word(make_cmd(pst_pkg::CMD_WAIT, 2, 0, 3000000, 1000));
		send_word(make_cmd(pst_pkg::CMD_WAIT, 2, 0, 1001000, 1000));
		send_word(make_cmd(pst_pkg::CMD_WAIT, 9, 0, 3000000, 1000));
		send_word(make_cmd(pst_pkg::CMD_ADVANCE, 0, 0, 0, 1000));
		send_word(make_cmd(pst_pkg::CMD_BLOCK, 0, 0, 0, 0));
		send_word(make_cmd(pst_pkg::CMD_READY, 0, 0, 0, 0));
		send_word(make_cmd(pst_pkg::CMD_SCHEDULE, 0, 0, 0, 2000001));
		send_word(make_cmd(pst_pkg::CMD_UNUSED, 3, 8'hFF, 63'h7FFF_FFFF_FFFF_FFFF,
			63'h7FFF_FFFF_FFFF_FFFF));
		send_word(make_cmd(pst_pkg::CMD_WAIT, 2, 0, 63'h7FFF_FFFF_FFFF_FFFF,
			63'h7FFF_FFFF_FFFF_FFFF));
		send_word(make_cmd(pst_pkg::CMD_ADVANCE, 0, 0, 0, 63'h7FFF_FFFF_FFFF_FFFF));
		send_word(make_cmd(pst_pkg::CMD_SCHEDULE, 0, 0, 0, 63'h7FFF_FFFF_FFFF_FFFF));
		for (int i = 0; i < 14; i++) send_word(make_cmd(pst_pkg::CMD_CREATE, 0, 8'(i), 0, 0));
		drain();
		clock_ns = 63'd1000;

		send_idle_pct = 35;
		recv_idle_pct = 47;
		write_reg(pst_pkg::REG_WAKE_TOL, 32'd0);
		write_reg(pst_pkg::REG_MIN_DELAY, 32'd0);
		write_reg(pst_pkg::REG_IDLE, 32'd15);
		random_items(400);
		drain();

		send_idle_pct = 47;
		recv_idle_pct = 35;
		write_reg(pst_pkg::REG_WAKE_TOL, 32'd1000000000);
		write_reg(pst_pkg::REG_MIN_DELAY, 32'd1000000000);
		write_reg(pst_pkg::REG_IDLE, 32'd3);
		random_items(400);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(pst_pkg::REG_WAKE_TOL, 32'd999999);
		write_reg(pst_pkg::REG_MIN_DELAY, 32'd1000000);
		write_reg(pst_pkg::REG_IDLE, 32'd0);
		random_items(480);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

@@ sim.f @@
rtl/pst_pkg.sv
rtl/pst_front.sv
rtl/pst_cmd_fifo.sv
rtl/pst_back.sv
rtl/priority_scheduler_timed_wakeup_top.sv
test/tb_top.sv
